// ----- rtl/differential_drive_odometry_macros.svh -----
// Assertion macros for the differential drive odometry checker.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define DDO_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, idle during reset.
`define DDO_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/ddo_pkg.sv -----
// Shared constants, register indexes and arithmetic helpers for the odometry block.
package ddo_pkg;

	localparam int VELOCITY_WINDOW_DEF  = 8;
	localparam int ANGLE_ITERATIONS_DEF = 24;

	localparam int INV_SEP_W = 23;
	localparam int THRESH_W  = 17;
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_INV_SEP = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH  = 8'd1;

	localparam logic [INV_SEP_W-1:0] INV_SEP_RST = 23'd145636;
	localparam logic [THRESH_W-1:0]  THRESH_RST  = 17'd7;

	localparam logic [31:0]        BAM_PER_RAD = 32'd683565276;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;

	// Arctangent of 2^-i in binary angle units.
	function automatic logic [31:0] atan_bam(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			5'd31: r = 32'h00000000;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	// Saturate a wide signed value to 32 bits.
	function automatic logic [31:0] sat32(input logic signed [68:0] v);
		logic [31:0] r;
		if (v > 69'sh0_7FFF_FFFF)
			r = 32'h7FFF_FFFF;
		else if (v < -69'sh0_8000_0000)
			r = 32'h8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	// Apply a sign to a quotient magnitude and saturate to 32 bits.
	function automatic logic [31:0] sat_quot(input logic neg, input logic [47:0] q);
		logic [31:0] r;
		if (neg) begin
			if (q > 48'h0000_8000_0000)
				r = 32'h8000_0000;
			else
				r = 32'h0 - q[31:0];
		end else begin
			if (q > 48'h0000_7FFF_FFFF)
				r = 32'h7FFF_FFFF;
			else
				r = q[31:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/ddo_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ddo_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- rtl/differential_drive_odometry.sv -----
// Differential drive odometry: a sequencer over one multiplier, one CORDIC and one divider.
//
// Each request carries a command flag in s_tuser and the left speed, right speed and timestamp
// in s_tdata. An integrate request forms v = (L+R)/2, w = (R-L)*inverse_wheel_separation and
// dt = timestamp - previous timestamp, advances the pose by midpoint integration when |w| is at
// or below straight_threshold and by exact arc integration otherwise, pushes v and w into
// rolling windows of VELOCITY_WINDOW samples and returns the pose with the window means. A
// clear request zeroes the pose and the reported means and keeps windows and time base. Every
// request yields exactly one result on m_tdata, held in an output register, so a new request
// may be taken while the previous result still waits. The block takes one request at a time
// and s_tready is low while it works. The time an integrate request takes is set by the
// 48-step restoring divider, which runs for the arc radius and for both means, and by the
// ANGLE_ITERATIONS-step CORDIC, which runs once on the midpoint path and twice on the arc
// path. All products go through one 34 by 34 bit multiplier, one per cycle. The window
// store is a RAM with no reset: entries are read only once the window has filled, so there
// is no clearing pass. Configuration writes are taken at any time on the cfg channel and
// must only arrive while the block is idle.
module differential_drive_odometry #(
	parameter int VELOCITY_WINDOW  = ddo_pkg::VELOCITY_WINDOW_DEF,
	parameter int ANGLE_ITERATIONS = ddo_pkg::ANGLE_ITERATIONS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ddo_pkg::INV_SEP_W-1:0] cfg_data,
	// request channel
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [95:0]                   s_tdata,  // left_velocity, right_velocity, timestamp
	input  logic                          s_tuser,  // cmd
	// result channel
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// x_position, y_position, heading_angle, linear_velocity_mean, angular_velocity_mean
	output logic [159:0]                  m_tdata
);

	localparam int PW    = (VELOCITY_WINDOW > 1) ? $clog2(VELOCITY_WINDOW) : 1;
	localparam int CW    = $clog2(VELOCITY_WINDOW + 1);
	localparam int SUM_W = 32 + $clog2(VELOCITY_WINDOW);
	localparam int DIV_W = 48;
	localparam int DCW   = $clog2(DIV_W + 1);

	// sequencer codes
	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_MW   = 5'd1;   // latch v and dt, multiply for w
	localparam logic [4:0] ST_W    = 5'd2;
	localparam logic [4:0] ST_P    = 5'd3;   // w * dt
	localparam logic [4:0] ST_MAG  = 5'd4;
	localparam logic [4:0] ST_QH   = 5'd5;   // heading change, upper half
	localparam logic [4:0] ST_QL   = 5'd6;   // heading change, lower half
	localparam logic [4:0] ST_QS   = 5'd7;
	localparam logic [4:0] ST_MD   = 5'd8;   // midpoint distance
	localparam logic [4:0] ST_D    = 5'd9;
	localparam logic [4:0] ST_CMW  = 5'd10;
	localparam logic [4:0] ST_MX   = 5'd11;
	localparam logic [4:0] ST_AX   = 5'd12;
	localparam logic [4:0] ST_AY   = 5'd13;
	localparam logic [4:0] ST_C0   = 5'd14;  // arc: old heading
	localparam logic [4:0] ST_C0W  = 5'd15;
	localparam logic [4:0] ST_C1   = 5'd16;  // arc: new heading
	localparam logic [4:0] ST_C1W  = 5'd17;
	localparam logic [4:0] ST_RS   = 5'd18;  // arc radius division
	localparam logic [4:0] ST_RW   = 5'd19;
	localparam logic [4:0] ST_RMX  = 5'd20;
	localparam logic [4:0] ST_RAX  = 5'd21;
	localparam logic [4:0] ST_RAY  = 5'd22;
	localparam logic [4:0] ST_WIN  = 5'd23;
	localparam logic [4:0] ST_DL   = 5'd24;
	localparam logic [4:0] ST_DLW  = 5'd25;
	localparam logic [4:0] ST_DA   = 5'd26;
	localparam logic [4:0] ST_DAW  = 5'd27;
	localparam logic [4:0] ST_DONE = 5'd28;

	logic [4:0] state_q;

	// configuration
	logic [ddo_pkg::INV_SEP_W-1:0] inv_q;
	logic [ddo_pkg::THRESH_W-1:0]  thr_q;

	// request latch
	logic               cmd_q;
	logic signed [31:0] l_q, r_in_q;
	logic [31:0]        ts_q;

	// pose and time base
	logic signed [31:0] x_q, y_q;
	logic [31:0]        hd_q, prev_q;

	// working values
	logic signed [31:0] v_q, w_q, d_q, rad_q;
	logic [31:0]        dt_q, dfull_q, dhalf_q;
	logic [63:0]        mag_q;
	logic               pneg_q;
	logic [32:0]        qacc_q;
	logic signed [31:0] c0_q, s0_q, c1_q, s1_q;

	// shared multiplier
	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] prod_q;

	// windows
	logic [PW-1:0]          pos_q;
	logic [CW-1:0]          cnt_q;
	logic signed [SUM_W-1:0] lsum_q, asum_q;
	logic signed [31:0]     lmean_q, amean_q;
	logic [63:0]            win_rd;
	logic                   win_we;

	// CORDIC
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic [4:0]         ccnt_q;
	logic               cbusy_q, cflip_q;
	logic               cord_start;
	logic [31:0]        cord_angle;
	logic signed [31:0] cos_c, sin_c;

	// divider
	logic [DIV_W-1:0] dnum_q;
	logic [31:0]      drem_q, dden_q;
	logic [DCW-1:0]   dcnt_q;
	logic             dneg_q;
	logic             div_start;
	logic [DIV_W-1:0] div_num;
	logic [31:0]      div_den;
	logic             div_neg;

	// output register
	logic         ov_q;
	logic [159:0] od_q;

	logic [32:0]  aw, av;
	logic [32:0]  qsum;
	logic         straight, win_full;
	logic [47:0]  lsum48, asum48;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = ov_q;
	assign m_tdata   = od_q;

	assign aw       = w_q[31] ? (33'd0 - 33'(w_q)) : 33'(w_q);
	assign av       = v_q[31] ? (33'd0 - 33'(v_q)) : 33'(v_q);
	assign straight = (aw <= 33'(thr_q));
	assign qsum     = qacc_q + prod_q[64:32];
	assign win_full = (cnt_q >= CW'(VELOCITY_WINDOW));
	assign lsum48   = 48'(lsum_q);
	assign asum48   = 48'(asum_q);
	assign win_we   = (state_q == ST_WIN);

	// Route operands to the multiplier by sequencer step.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MW: begin
				mul_a = 34'(r_in_q) - 34'(l_q);
				mul_b = $signed({11'd0, inv_q});
			end
			ST_P: begin
				mul_a = 34'(w_q);
				mul_b = $signed({2'd0, dt_q});
			end
			ST_QH: begin
				mul_a = $signed({2'd0, mag_q[63:32]});
				mul_b = $signed({2'd0, ddo_pkg::BAM_PER_RAD});
			end
			ST_QL: begin
				mul_a = $signed({2'd0, mag_q[31:0]});
				mul_b = $signed({2'd0, ddo_pkg::BAM_PER_RAD});
			end
			ST_MD: begin
				mul_a = 34'(v_q);
				mul_b = $signed({2'd0, dt_q});
			end
			ST_MX: begin
				mul_a = 34'(d_q);
				mul_b = 34'(c0_q);
			end
			ST_AX: begin
				mul_a = 34'(d_q);
				mul_b = 34'(s0_q);
			end
			ST_RMX: begin
				mul_a = 34'(rad_q);
				mul_b = 34'(s1_q) - 34'(s0_q);
			end
			ST_RAX: begin
				mul_a = 34'(rad_q);
				mul_b = 34'(c0_q) - 34'(c1_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Start strobes and operands for the CORDIC and the divider.
	always_comb begin
		cord_start = 1'b0;
		cord_angle = hd_q;
		div_start  = 1'b0;
		div_num    = {av[31:0], 16'd0};
		div_den    = aw[31:0];
		div_neg    = v_q[31] ^ w_q[31];
		unique case (state_q)
			ST_D: begin
				cord_start = 1'b1;
				cord_angle = hd_q + dhalf_q;
			end
			ST_C0, ST_C1: cord_start = 1'b1;
			ST_RS: div_start = 1'b1;
			ST_DL: begin
				div_start = 1'b1;
				div_num   = lsum_q[SUM_W-1] ? (48'd0 - lsum48) : lsum48;
				div_den   = 32'(cnt_q);
				div_neg   = lsum_q[SUM_W-1];
			end
			ST_DA: begin
				div_start = 1'b1;
				div_num   = asum_q[SUM_W-1] ? (48'd0 - asum48) : asum48;
				div_den   = 32'(cnt_q);
				div_neg   = asum_q[SUM_W-1];
			end
			default: begin
				cord_start = 1'b0;
				div_start  = 1'b0;
			end
		endcase
	end

	// Clamp the rotated vector and undo the half-turn fold.
	always_comb begin
		logic signed [33:0] xc, yc;
		xc = (cx_q > ddo_pkg::ONE_Q30) ? ddo_pkg::ONE_Q30 :
			(cx_q < -ddo_pkg::ONE_Q30) ? -ddo_pkg::ONE_Q30 : cx_q;
		yc = (cy_q > ddo_pkg::ONE_Q30) ? ddo_pkg::ONE_Q30 :
			(cy_q < -ddo_pkg::ONE_Q30) ? -ddo_pkg::ONE_Q30 : cy_q;
		if (cflip_q) begin
			xc = -xc;
			yc = -yc;
		end
		cos_c = xc[31:0];
		sin_c = yc[31:0];
	end

	// Configuration registers; writes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= ddo_pkg::INV_SEP_RST;
			thr_q <= ddo_pkg::THRESH_RST;
		end else if (cfg_valid) begin
			if (cfg_index == ddo_pkg::REG_INV_SEP)
				inv_q <= cfg_data;
			else if (cfg_index == ddo_pkg::REG_THRESH)
				thr_q <= cfg_data[ddo_pkg::THRESH_W-1:0];
		end
	end

	// CORDIC in rotation mode, one micro-rotation a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cbusy_q <= 1'b0;
			ccnt_q  <= '0;
			cflip_q <= 1'b0;
			cx_q    <= '0;
			cy_q    <= '0;
			cz_q    <= '0;
		end else if (cord_start) begin
			logic [31:0] a_fold;
			logic        flip;
			flip     = cord_angle[31] ^ cord_angle[30];
			a_fold   = flip ? (cord_angle + 32'h8000_0000) : cord_angle;
			cflip_q <= flip;
			cz_q    <= 34'($signed(a_fold));
			cx_q    <= ddo_pkg::CORDIC_GAIN;
			cy_q    <= '0;
			ccnt_q  <= '0;
			cbusy_q <= 1'b1;
		end else if (cbusy_q) begin
			logic signed [33:0] sx, sy, at;
			sx = cy_q >>> ccnt_q;
			sy = cx_q >>> ccnt_q;
			at = $signed({2'd0, ddo_pkg::atan_bam(ccnt_q)});
			if (!cz_q[33]) begin
				cx_q <= cx_q - sx;
				cy_q <= cy_q + sy;
				cz_q <= cz_q - at;
			end else begin
				cx_q <= cx_q + sx;
				cy_q <= cy_q - sy;
				cz_q <= cz_q + at;
			end
			ccnt_q <= ccnt_q + 5'd1;
			if (ccnt_q == 5'(ANGLE_ITERATIONS - 1))
				cbusy_q <= 1'b0;
		end
	end

	// Restoring divider on magnitudes, one quotient bit a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
			dnum_q <= '0;
			drem_q <= '0;
			dden_q <= '0;
			dneg_q <= 1'b0;
		end else if (div_start) begin
			dnum_q <= div_num;
			dden_q <= div_den;
			dneg_q <= div_neg;
			drem_q <= '0;
			dcnt_q <= DCW'(DIV_W);
		end else if (dcnt_q != '0) begin
			logic [32:0] rs;
			logic        ge;
			rs = {drem_q, dnum_q[DIV_W-1]};
			ge = (rs >= {1'b0, dden_q});
			drem_q <= ge ? 32'(rs - {1'b0, dden_q}) : rs[31:0];
			dnum_q <= {dnum_q[DIV_W-2:0], ge};
			dcnt_q <= dcnt_q - DCW'(1);
		end
	end

	// Product register of the shared multiplier.
	always_ff @(posedge clk)
		prod_q <= mul_a * mul_b;

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			x_q     <= '0;
			y_q     <= '0;
			hd_q    <= '0;
			prev_q  <= '0;
			lsum_q  <= '0;
			asum_q  <= '0;
			pos_q   <= '0;
			cnt_q   <= '0;
			lmean_q <= '0;
			amean_q <= '0;
			ov_q    <= 1'b0;
		end else begin
			// load a finished result when the output register is free, else drain it
			if (state_q == ST_DONE && (!ov_q || m_tready))
				ov_q <= 1'b1;
			else if (m_tready)
				ov_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						cmd_q   <= s_tuser;
						l_q     <= s_tdata[31:0];
						r_in_q  <= s_tdata[63:32];
						ts_q    <= s_tdata[95:64];
						state_q <= ST_MW;
					end
				end
				ST_MW: begin
					if (cmd_q) begin
						// clear: pose and reported means only
						x_q     <= '0;
						y_q     <= '0;
						hd_q    <= '0;
						lmean_q <= '0;
						amean_q <= '0;
						state_q <= ST_DONE;
					end else begin
						v_q     <= 32'((34'(l_q) + 34'(r_in_q)) >>> 1);
						dt_q    <= ts_q - prev_q;
						prev_q  <= ts_q;
						state_q <= ST_W;
					end
				end
				ST_W: begin
					w_q     <= ddo_pkg::sat32(69'(prod_q >>> 16));
					state_q <= ST_P;
				end
				ST_P: state_q <= ST_MAG;
				ST_MAG: begin
					pneg_q  <= prod_q[67];
					mag_q   <= prod_q[67] ? 64'(-prod_q) : prod_q[63:0];
					state_q <= ST_QH;
				end
				ST_QH: state_q <= ST_QL;
				ST_QL: begin
					qacc_q  <= prod_q[32:0];
					state_q <= ST_QS;
				end
				ST_QS: begin
					dfull_q <= pneg_q ? (32'd0 - qsum[31:0]) : qsum[31:0];
					dhalf_q <= pneg_q ? (32'd0 - qsum[32:1]) : qsum[32:1];
					state_q <= straight ? ST_MD : ST_C0;
				end
				ST_MD: state_q <= ST_D;
				ST_D: begin
					d_q     <= ddo_pkg::sat32(69'(prod_q >>> 16));
					state_q <= ST_CMW;
				end
				ST_CMW: begin
					if (!cbusy_q) begin
						c0_q    <= cos_c;
						s0_q    <= sin_c;
						state_q <= ST_MX;
					end
				end
				ST_MX: state_q <= ST_AX;
				ST_AX: begin
					x_q     <= ddo_pkg::sat32(69'(x_q) + 69'(prod_q >>> 30));
					state_q <= ST_AY;
				end
				ST_AY: begin
					y_q     <= ddo_pkg::sat32(69'(y_q) + 69'(prod_q >>> 30));
					hd_q    <= hd_q + dfull_q;
					state_q <= ST_WIN;
				end
				ST_C0: state_q <= ST_C0W;
				ST_C0W: begin
					if (!cbusy_q) begin
						c0_q    <= cos_c;
						s0_q    <= sin_c;
						hd_q    <= hd_q + dfull_q;
						state_q <= ST_C1;
					end
				end
				ST_C1: state_q <= ST_C1W;
				ST_C1W: begin
					if (!cbusy_q) begin
						c1_q    <= cos_c;
						s1_q    <= sin_c;
						state_q <= ST_RS;
					end
				end
				ST_RS: state_q <= ST_RW;
				ST_RW: begin
					if (dcnt_q == '0) begin
						rad_q   <= ddo_pkg::sat_quot(dneg_q, dnum_q);
						state_q <= ST_RMX;
					end
				end
				ST_RMX: state_q <= ST_RAX;
				ST_RAX: begin
					x_q     <= ddo_pkg::sat32(69'(x_q) + 69'(prod_q >>> 30));
					state_q <= ST_RAY;
				end
				ST_RAY: begin
					y_q     <= ddo_pkg::sat32(69'(y_q) + 69'(prod_q >>> 30));
					state_q <= ST_WIN;
				end
				ST_WIN: begin
					// drop the oldest sample once the window is full
					lsum_q <= lsum_q + SUM_W'(v_q)
						- (win_full ? SUM_W'($signed(win_rd[31:0])) : SUM_W'(0));
					asum_q <= asum_q + SUM_W'(w_q)
						- (win_full ? SUM_W'($signed(win_rd[63:32])) : SUM_W'(0));
					pos_q  <= (pos_q == PW'(VELOCITY_WINDOW - 1)) ? PW'(0) : pos_q + PW'(1);
					if (!win_full)
						cnt_q <= cnt_q + CW'(1);
					state_q <= ST_DL;
				end
				ST_DL: state_q <= ST_DLW;
				ST_DLW: begin
					if (dcnt_q == '0) begin
						lmean_q <= ddo_pkg::sat_quot(dneg_q, dnum_q);
						state_q <= ST_DA;
					end
				end
				ST_DA: state_q <= ST_DAW;
				ST_DAW: begin
					if (dcnt_q == '0) begin
						amean_q <= ddo_pkg::sat_quot(dneg_q, dnum_q);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!ov_q || m_tready) begin
						od_q    <= {amean_q, lmean_q, hd_q, y_q, x_q};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Window store: one word of {w, v} per sample, read at the slot about to be replaced.
	ddo_ram #(
		.WIDTH (64),
		.DEPTH (VELOCITY_WINDOW)
	) u_win (
		.clk     (clk),
		.wr_en   (win_we),
		.wr_addr (pos_q),
		.wr_data ({w_q, v_q}),
		.rd_addr (pos_q),
		.rd_data (win_rd)
	);

endmodule

// ----- rtl/ddo_checker.sv -----
// Port-level checker for the differential drive odometry block, bound to the top level.
`include "differential_drive_odometry_macros.svh"

module ddo_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [159:0] m_tdata
);

	`DDO_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
	`DDO_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "request taken while the previous one is at work")
	`DDO_ASSERT_IMP(a_result_from_work, $rose(m_tvalid), $past(!s_tready), "result appeared without a request at work")

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (.*);
